FILE: rtl/etg_pkg.sv
// Package for the easing tween generator: sequencer states, ease codes,
// register indexes, CORDIC and power-of-two constant tables.
// No dependencies; used by etg_cordic and easing_tween_generator.
package etg_pkg;

    // Number formats.
    localparam int FRAC_BITS   = 16;
    localparam int TIME_BITS   = 24;
    localparam int PHASE_W     = FRAC_BITS + 1;
    localparam logic [PHASE_W-1:0] ONE  = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] HALF = PHASE_W'(1) << (FRAC_BITS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EASE_TYPE = 3'd0;
    localparam logic [2:0] CFG_START     = 3'd1;
    localparam logic [2:0] CFG_END       = 3'd2;
    localparam logic [2:0] CFG_DURATION  = 3'd3;
    localparam logic [2:0] CFG_DELAY     = 3'd4;
    localparam logic [2:0] CFG_REPEAT    = 3'd5;

    // Ease codes.
    localparam logic [4:0] EASE_POLY_FIRST   = 5'd1;
    localparam logic [4:0] EASE_POLY_LAST    = 5'd12;
    localparam logic [4:0] EASE_SINE_IN      = 5'd13;
    localparam logic [4:0] EASE_SINE_OUT     = 5'd14;
    localparam logic [4:0] EASE_SINE_INOUT   = 5'd15;
    localparam logic [4:0] EASE_EXPO_IN      = 5'd16;
    localparam logic [4:0] EASE_EXPO_OUT     = 5'd17;
    localparam logic [4:0] EASE_EXPO_INOUT   = 5'd18;
    localparam logic [4:0] EASE_CIRC_IN      = 5'd19;
    localparam logic [4:0] EASE_CIRC_OUT     = 5'd20;
    localparam logic [4:0] EASE_CIRC_INOUT   = 5'd21;
    localparam logic [4:0] EASE_BOUNCE_FIRST = 5'd22;
    localparam logic [4:0] EASE_BOUNCE_LAST  = 5'd24;

    typedef enum logic [1:0] {
        KIND_IN,
        KIND_OUT,
        KIND_INOUT
    } t_kind;

    // Direction of a curve family member.
    function automatic t_kind ease_kind(logic [4:0] code);
        t_kind k;
        case (code)
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19: k = KIND_IN;
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20: k = KIND_OUT;
            default: k = KIND_INOUT;
        endcase
        return k;
    endfunction

    // Number of multiplications for the polynomial curves (power minus one).
    function automatic logic [2:0] poly_muls(logic [4:0] code);
        logic [2:0] m;
        case (code)
            5'd1, 5'd2, 5'd3:    m = 3'd1;
            5'd4, 5'd5, 5'd6:    m = 3'd2;
            5'd7, 5'd8, 5'd9:    m = 3'd3;
            default:             m = 3'd4;
        endcase
        return m;
    endfunction

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_PHASE,
        ST_DISPATCH,
        ST_POLY,
        ST_POLY_FIN,
        ST_ZMUL,
        ST_CSTART,
        ST_CWAIT,
        ST_SINSQ,
        ST_POW2,
        ST_POW2_FIN,
        ST_CIRC,
        ST_SQRT,
        ST_CIRC_FIN,
        ST_BOUNCE,
        ST_SCALE
    } t_state;

    // CORDIC constants, Q2.30.
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    // CORDIC result handed back to the sequencer.
    typedef struct packed {
        logic        done;
        logic [30:0] sin;
        logic [30:0] cos;
    } t_cordic_res;

    // Integer square root, rounded down; evaluated at elaboration only.
    function automatic logic [63:0] isqrt_const(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] w;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        w = v;
        for (int i = 0; i < 32; i++) begin
            if (w >= r + b) begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factor 2^(-2^-(k+1)) in Q0.30 built as a chain of square roots.
    function automatic logic [29:0] pow2_const(int k);
        logic [63:0] c;
        c = isqrt_const(64'd1 << 59);
        for (int j = 0; j < k; j++) begin
            c = isqrt_const(c << 30);
        end
        return c[29:0];
    endfunction

    localparam logic [29:0] POW2_C [FRAC_BITS] = '{
        pow2_const(0),  pow2_const(1),  pow2_const(2),  pow2_const(3),
        pow2_const(4),  pow2_const(5),  pow2_const(6),  pow2_const(7),
        pow2_const(8),  pow2_const(9),  pow2_const(10), pow2_const(11),
        pow2_const(12), pow2_const(13), pow2_const(14), pow2_const(15)
    };

endpackage

FILE: rtl/etg_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine in Q2.30.
// Depends on etg_pkg for the arctangent table, gain and result struct.
module etg_cordic (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [32:0]     i_angle,
    output etg_pkg::t_cordic_res   o_res
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_step;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [32:0] r_z;

    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [32:0] atan_v;

    // One micro-rotation per cycle through the shared shifters.
    assign x_sh   = r_x >>> r_step;
    assign y_sh   = r_y >>> r_step;
    assign atan_v = $signed({1'b0, etg_pkg::ATAN_Q30[r_step]});

    // Control. The step count stops at the last table entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(etg_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
        end
    end

    // Rotation datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= etg_pkg::CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_angle;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
    end

    // Results clamped to the range zero to one.
    always_comb begin
        o_res.done = r_done;
        if (r_y < 0) begin
            o_res.sin = '0;
        end else if (r_y > $signed({3'b0, etg_pkg::Q30_ONE})) begin
            o_res.sin = etg_pkg::Q30_ONE;
        end else begin
            o_res.sin = r_y[30:0];
        end
        if (r_x < 0) begin
            o_res.cos = '0;
        end else if (r_x > $signed({3'b0, etg_pkg::Q30_ONE})) begin
            o_res.cos = etg_pkg::Q30_ONE;
        end else begin
            o_res.cos = r_x[30:0];
        end
    end

endmodule

FILE: rtl/easing_tween_generator.sv
// Top level of the easing tween generator: time keeping, phase divider,
// ease sequencer around one shared multiplier, and stream ports.
// Depends on etg_pkg and etg_cordic.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata elapsed_ticks, tuser hold
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata value, tuser done_res,wrapped
//  cfg       in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// A held tick, one at or before the end of the delay or with zero duration, or one
// at the end of the run is finished in the evaluation state. An eased tick runs the 40-step
// restoring phase divider, any polynomial, sine, expo, circ or bounce states, and scaling.
// The next tick is accepted once the result has been taken from the output register.
// Reset is synchronous and clears time, last value, done, config, state and output valid.
// Configuration transactions are always accepted.
module easing_tween_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] elapsed_ticks
    input  logic [0:0]  i_s_axis_tuser,   // [0] hold
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] value
    output logic [1:0]  o_m_axis_tuser,   // [0] done_res, [1] wrapped
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int PW = etg_pkg::PHASE_W;

    // Configuration registers.
    logic [4:0]  r_ease;
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [23:0] r_dur;
    logic [23:0] r_delay;
    logic        r_repeat;

    // Tween state.
    logic [23:0] r_run_time;
    logic [31:0] r_last;
    logic        r_done_flag;

    // Sequencer and datapath registers.
    etg_pkg::t_state r_state, n_state;
    logic [23:0] r_t,       n_t;
    logic        r_hold,    n_hold;
    logic [24:0] r_rem,     n_rem;
    logic [39:0] r_quo,     n_quo;
    logic [5:0]  r_cnt,     n_cnt;
    logic [PW-1:0] r_p,     n_p;
    logic [19:0] r_x,       n_x;
    logic [32:0] r_acc,     n_acc;
    logic [PW-1:0] r_k,     n_k;
    logic [19:0] r_pa,      n_pa;
    logic [33:0] r_sq_op,   n_sq_op;
    logic [33:0] r_sq_res,  n_sq_res;
    logic [33:0] r_sq_one,  n_sq_one;
    logic [PW-1:0] r_e,     n_e;

    // Output register.
    logic        r_oval;
    logic [31:0] r_ovalue;
    logic        r_odone;
    logic        r_owrap;

    // Finishing a tick.
    logic        fin;
    logic [31:0] fin_value;
    logic        fin_wrap;
    logic        fin_done;
    logic [23:0] fin_time;

    logic        s_accept;
    logic        cordic_start;
    etg_pkg::t_cordic_res cordic_res;

    // Shared multiplier.
    logic signed [33:0] mul_a;
    logic [31:0]        mul_b;
    logic signed [65:0] mul_p;

    // Helpers.
    logic [24:0] t_sum;
    logic [24:0] endp_sum;
    logic [23:0] endp;
    logic [24:0] div_sh;
    logic [PW-1:0] q;
    logic [PW-1:0] p2;
    logic [PW-1:0] q2;
    logic        p_lo;
    logic [19:0] p11;
    logic [19:0] p20;
    logic [PW-1:0] e_cl;
    logic [33:0] sq_trial;
    logic [30:0] pow_r;
    logic [PW-1:0] pow_v;
    logic [PW-1:0] sq_v;
    logic signed [33:0] diff;
    etg_pkg::t_kind kind;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == etg_pkg::ST_IDLE) && !r_oval;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = r_ovalue;
    assign o_m_axis_tuser  = {r_owrap, r_odone};

    assign kind   = etg_pkg::ease_kind(r_ease);
    assign t_sum  = {1'b0, r_run_time} + {9'b0, i_s_axis_tdata};
    assign endp_sum = {1'b0, r_delay} + {1'b0, r_dur};
    assign endp   = endp_sum[24] ? etg_pkg::TIME_MAX : endp_sum[23:0];
    assign div_sh = {r_rem[23:0], r_quo[39]};
    assign q      = etg_pkg::ONE - r_p;
    assign p2     = {r_p[PW-2:0], 1'b0};
    assign q2     = {q[PW-2:0], 1'b0};
    assign p_lo   = r_p < etg_pkg::HALF;
    assign p11    = ({3'b0, r_p} << 3) + ({3'b0, r_p} << 1) + {3'b0, r_p};
    assign p20    = ({3'b0, r_p} << 4) + ({3'b0, r_p} << 2);
    assign e_cl   = (r_e > etg_pkg::ONE) ? etg_pkg::ONE : r_e;
    assign sq_trial = r_sq_res + r_sq_one;
    assign pow_r  = r_acc[30:0] >> r_pa[19:16];
    assign pow_v  = pow_r[30:14];
    assign sq_v   = r_sq_res[PW-1:0];
    assign diff   = $signed({{2{r_end[31]}}, r_end}) - $signed({{2{r_start[31]}}, r_start});

    etg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle ($signed(r_acc)),
        .o_res   (cordic_res)
    );

    assign cordic_start = (r_state == etg_pkg::ST_CSTART);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            etg_pkg::ST_POLY: begin
                mul_a = {17'b0, r_acc[16:0]};
                mul_b = {15'b0, r_x[16:0]};
            end
            etg_pkg::ST_ZMUL: begin
                mul_a = {17'b0, r_p};
                mul_b = etg_pkg::HALF_PI_Q30;
            end
            etg_pkg::ST_SINSQ: begin
                mul_a = {3'b0, cordic_res.sin};
                mul_b = {1'b0, cordic_res.sin};
            end
            etg_pkg::ST_POW2: begin
                mul_a = {1'b0, r_acc};
                mul_b = {2'b0, etg_pkg::POW2_C[r_cnt[3:0]]};
            end
            etg_pkg::ST_CIRC, etg_pkg::ST_BOUNCE: begin
                mul_a = {14'b0, r_x};
                mul_b = {12'b0, r_x};
            end
            etg_pkg::ST_SCALE: begin
                mul_a = diff;
                mul_b = {15'b0, e_cl};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            etg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = etg_pkg::ST_EVAL;
                end
            end
            etg_pkg::ST_EVAL: begin
                if (r_hold || r_t >= endp || r_t <= r_delay || r_dur == '0) begin
                    n_state = etg_pkg::ST_IDLE;
                end else begin
                    n_state = etg_pkg::ST_DIV;
                end
            end
            etg_pkg::ST_DIV: begin
                if (r_cnt == 6'd39) begin
                    n_state = etg_pkg::ST_PHASE;
                end
            end
            etg_pkg::ST_PHASE: n_state = etg_pkg::ST_DISPATCH;
            etg_pkg::ST_DISPATCH: begin
                if (r_ease >= etg_pkg::EASE_POLY_FIRST && r_ease <= etg_pkg::EASE_POLY_LAST) begin
                    n_state = etg_pkg::ST_POLY;
                end else if (r_ease >= etg_pkg::EASE_SINE_IN
                             && r_ease <= etg_pkg::EASE_SINE_INOUT) begin
                    n_state = etg_pkg::ST_ZMUL;
                end else if (r_ease >= etg_pkg::EASE_EXPO_IN
                             && r_ease <= etg_pkg::EASE_EXPO_INOUT) begin
                    n_state = etg_pkg::ST_POW2;
                end else if (r_ease >= etg_pkg::EASE_CIRC_IN
                             && r_ease <= etg_pkg::EASE_CIRC_INOUT) begin
                    n_state = etg_pkg::ST_CIRC;
                end else if (r_ease >= etg_pkg::EASE_BOUNCE_FIRST
                             && r_ease <= etg_pkg::EASE_BOUNCE_LAST) begin
                    n_state = etg_pkg::ST_BOUNCE;
                end else begin
                    n_state = etg_pkg::ST_SCALE;
                end
            end
            etg_pkg::ST_POLY: begin
                if (r_cnt == 6'd1) begin
                    n_state = etg_pkg::ST_POLY_FIN;
                end
            end
            etg_pkg::ST_POLY_FIN: n_state = etg_pkg::ST_SCALE;
            etg_pkg::ST_ZMUL:     n_state = etg_pkg::ST_CSTART;
            etg_pkg::ST_CSTART:   n_state = etg_pkg::ST_CWAIT;
            etg_pkg::ST_CWAIT: begin
                if (cordic_res.done) begin
                    if (r_ease == etg_pkg::EASE_SINE_INOUT) begin
                        n_state = etg_pkg::ST_SINSQ;
                    end else begin
                        n_state = etg_pkg::ST_SCALE;
                    end
                end
            end
            etg_pkg::ST_SINSQ: n_state = etg_pkg::ST_SCALE;
            etg_pkg::ST_POW2: begin
                if (r_cnt == 6'(etg_pkg::FRAC_BITS - 1)) begin
                    n_state = etg_pkg::ST_POW2_FIN;
                end
            end
            etg_pkg::ST_POW2_FIN: n_state = etg_pkg::ST_SCALE;
            etg_pkg::ST_CIRC:     n_state = etg_pkg::ST_SQRT;
            etg_pkg::ST_SQRT: begin
                if (r_cnt == 6'd16) begin
                    n_state = etg_pkg::ST_CIRC_FIN;
                end
            end
            etg_pkg::ST_CIRC_FIN: n_state = etg_pkg::ST_SCALE;
            etg_pkg::ST_BOUNCE:   n_state = etg_pkg::ST_SCALE;
            etg_pkg::ST_SCALE:    n_state = etg_pkg::ST_IDLE;
            default:              n_state = etg_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values and tick completion.
    always_comb begin
        n_t      = r_t;
        n_hold   = r_hold;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_p      = r_p;
        n_x      = r_x;
        n_acc    = r_acc;
        n_k      = r_k;
        n_pa     = r_pa;
        n_sq_op  = r_sq_op;
        n_sq_res = r_sq_res;
        n_sq_one = r_sq_one;
        n_e      = r_e;
        fin       = 1'b0;
        fin_value = r_last;
        fin_wrap  = 1'b0;
        fin_done  = r_done_flag;
        fin_time  = r_run_time;
        case (r_state)
            etg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_t    = t_sum[24] ? etg_pkg::TIME_MAX : t_sum[23:0];
                    n_hold = i_s_axis_tuser[0];
                end
            end
            // Decide between hold, end of run, waiting and easing.
            etg_pkg::ST_EVAL: begin
                if (r_hold) begin
                    fin = 1'b1;
                end else if (r_t >= endp) begin
                    fin = 1'b1;
                    if (r_repeat) begin
                        fin_time  = '0;
                        fin_done  = 1'b0;
                        fin_value = r_start;
                        fin_wrap  = 1'b1;
                    end else begin
                        fin_time  = r_t;
                        fin_done  = 1'b1;
                        fin_value = r_end;
                    end
                end else if (r_t <= r_delay || r_dur == '0) begin
                    fin       = 1'b1;
                    fin_time  = r_t;
                    fin_value = r_start;
                end else begin
                    n_quo = {r_t - r_delay, 16'b0};
                    n_rem = '0;
                    n_cnt = '0;
                end
            end
            // Restoring division, one quotient bit per cycle.
            etg_pkg::ST_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (div_sh >= {1'b0, r_dur}) begin
                    n_rem = div_sh - {1'b0, r_dur};
                    n_quo = {r_quo[38:0], 1'b1};
                end else begin
                    n_rem = div_sh;
                    n_quo = {r_quo[38:0], 1'b0};
                end
            end
            etg_pkg::ST_PHASE: begin
                n_p = (r_quo > {23'b0, etg_pkg::ONE}) ? etg_pkg::ONE : r_quo[PW-1:0];
            end
            // Operand setup for the selected curve.
            etg_pkg::ST_DISPATCH: begin
                case (kind)
                    etg_pkg::KIND_IN:  n_x = {3'b0, r_p};
                    etg_pkg::KIND_OUT: n_x = {3'b0, q};
                    default:           n_x = {3'b0, p_lo ? p2 : q2};
                endcase
                n_acc = {16'b0, n_x[16:0]};
                n_cnt = {3'b0, etg_pkg::poly_muls(r_ease)};
                if (r_ease >= etg_pkg::EASE_EXPO_IN && r_ease <= etg_pkg::EASE_EXPO_INOUT) begin
                    n_acc = {2'b0, etg_pkg::Q30_ONE};
                    n_cnt = '0;
                    case (kind)
                        etg_pkg::KIND_IN:  n_pa = ({3'b0, q} << 3) + ({3'b0, q} << 1);
                        etg_pkg::KIND_OUT: n_pa = ({3'b0, r_p} << 3) + ({3'b0, r_p} << 1);
                        default: begin
                            if (p_lo) begin
                                n_pa = 20'd720896 - p20;
                            end else begin
                                n_pa = p20 - 20'd589824;
                            end
                        end
                    endcase
                end
                if (r_ease == etg_pkg::EASE_CIRC_IN) begin
                    n_x = {3'b0, r_p};
                end else if (r_ease == etg_pkg::EASE_CIRC_OUT) begin
                    n_x = {3'b0, q};
                end
                if (r_ease >= etg_pkg::EASE_BOUNCE_FIRST
                    && r_ease <= etg_pkg::EASE_BOUNCE_LAST) begin
                    if (p11 < 20'd262144) begin
                        n_x = p11;
                        n_k = '0;
                    end else if (p11 < 20'd524288) begin
                        n_x = (p11 >= 20'd393216) ? p11 - 20'd393216 : 20'd393216 - p11;
                        n_k = PW'(49152);
                    end else if (p11 < 20'd655360) begin
                        n_x = (p11 >= 20'd589824) ? p11 - 20'd589824 : 20'd589824 - p11;
                        n_k = PW'(61440);
                    end else begin
                        n_x = (p11 >= 20'd688128) ? p11 - 20'd688128 : 20'd688128 - p11;
                        n_k = PW'(64512);
                    end
                end
                n_e = r_p;
            end
            // Repeated fixed-point products for the power curves.
            etg_pkg::ST_POLY: begin
                n_acc = {16'b0, mul_p[32:16]};
                n_cnt = r_cnt - 6'd1;
            end
            etg_pkg::ST_POLY_FIN: begin
                case (kind)
                    etg_pkg::KIND_IN:  n_e = r_acc[16:0];
                    etg_pkg::KIND_OUT: n_e = etg_pkg::ONE - r_acc[16:0];
                    default: begin
                        if (p_lo) begin
                            n_e = r_acc[16:0] >> 1;
                        end else begin
                            n_e = etg_pkg::ONE - (r_acc[16:0] >> 1);
                        end
                    end
                endcase
            end
            // Angle p * pi/2 in Q2.30 for the rotation unit.
            etg_pkg::ST_ZMUL: begin
                n_acc = mul_p[48:16];
            end
            etg_pkg::ST_CWAIT: begin
                if (r_ease == etg_pkg::EASE_SINE_IN) begin
                    n_e = etg_pkg::ONE - cordic_res.cos[30:14];
                end else begin
                    n_e = cordic_res.sin[30:14];
                end
            end
            etg_pkg::ST_SINSQ: begin
                n_e = mul_p[60:44];
            end
            // One conditional factor per fraction bit of the exponent.
            etg_pkg::ST_POW2: begin
                n_cnt = r_cnt + 6'd1;
                if (r_pa[4'(etg_pkg::FRAC_BITS - 1) - r_cnt[3:0]]) begin
                    n_acc = mul_p[62:30];
                end
            end
            etg_pkg::ST_POW2_FIN: begin
                case (kind)
                    etg_pkg::KIND_IN:  n_e = pow_v;
                    etg_pkg::KIND_OUT: n_e = etg_pkg::ONE - pow_v;
                    default:           n_e = p_lo ? pow_v : etg_pkg::ONE - pow_v;
                endcase
            end
            // Square root argument (1 - x*x), scaled for the root.
            etg_pkg::ST_CIRC: begin
                n_sq_op  = {1'b0, etg_pkg::ONE - mul_p[32:16], 16'b0};
                n_sq_res = '0;
                n_sq_one = 34'h1_0000_0000;
                n_cnt    = '0;
            end
            etg_pkg::ST_SQRT: begin
                n_cnt    = r_cnt + 6'd1;
                n_sq_one = r_sq_one >> 2;
                if (r_sq_op >= sq_trial) begin
                    n_sq_op  = r_sq_op - sq_trial;
                    n_sq_res = (r_sq_res >> 1) + r_sq_one;
                end else begin
                    n_sq_res = r_sq_res >> 1;
                end
            end
            etg_pkg::ST_CIRC_FIN: begin
                case (kind)
                    etg_pkg::KIND_IN:  n_e = etg_pkg::ONE - sq_v;
                    etg_pkg::KIND_OUT: n_e = sq_v;
                    default: begin
                        if (p_lo) begin
                            n_e = (etg_pkg::ONE - sq_v) >> 1;
                        end else begin
                            n_e = PW'(({1'b0, sq_v} + {1'b0, etg_pkg::ONE}) >> 1);
                        end
                    end
                endcase
            end
            etg_pkg::ST_BOUNCE: begin
                n_e = mul_p[36:20] + r_k;
            end
            // Final interpolation between start and end values.
            etg_pkg::ST_SCALE: begin
                fin       = 1'b1;
                fin_time  = r_t;
                fin_value = r_start + mul_p[47:16];
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // Configuration transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ease   <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_dur    <= '0;
            r_delay  <= '0;
            r_repeat <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                etg_pkg::CFG_EASE_TYPE: r_ease   <= i_cfg_data[4:0];
                etg_pkg::CFG_START:     r_start  <= i_cfg_data;
                etg_pkg::CFG_END:       r_end    <= i_cfg_data;
                etg_pkg::CFG_DURATION:  r_dur    <= i_cfg_data[23:0];
                etg_pkg::CFG_DELAY:     r_delay  <= i_cfg_data[23:0];
                etg_pkg::CFG_REPEAT:    r_repeat <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state, tween state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etg_pkg::ST_IDLE;
            r_run_time  <= '0;
            r_last      <= '0;
            r_done_flag <= 1'b0;
            r_oval      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_oval && i_m_axis_tready) begin
                r_oval <= 1'b0;
            end
            if (fin) begin
                r_oval      <= 1'b1;
                r_run_time  <= fin_time;
                r_last      <= fin_value;
                r_done_flag <= fin_done;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_hold   <= n_hold;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_p      <= n_p;
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_k      <= n_k;
        r_pa     <= n_pa;
        r_sq_op  <= n_sq_op;
        r_sq_res <= n_sq_res;
        r_sq_one <= n_sq_one;
        r_e      <= n_e;
        if (fin) begin
            r_ovalue <= fin_value;
            r_odone  <= fin_done;
            r_owrap  <= fin_wrap;
        end
    end

endmodule

FILE: tb/tb_easing_tween_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for easing_tween_generator: ticks are streamed in, results are
// compared against a cycle-free predictor kept in a scoreboard class. Depends on etg_pkg.
module tb_easing_tween_generator;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint P_ONE = 64'd1 << 16;
    localparam longint P_HALF = P_ONE >> 1;
    localparam longint T_MAX = (64'd1 << 24) - 1;

    typedef struct {
        logic [31:0] value;
        logic        done_res;
        logic        wrapped;
    } t_tween_out;

    // Scoreboard: predicts one result per accepted tick and checks the stream of results.
    class tween_scoreboard;
        logic [4:0]  ease_code;
        logic [31:0] start_val, end_val;
        logic [23:0] dur, dly;
        logic        rep;
        longint unsigned run_t;
        logic [31:0] last_val;
        logic        done_st;
        t_tween_out  expected_q[$];
        int          mismatches;

        function new();
            ease_code = '0; start_val = '0; end_val = '0; dur = '0; dly = '0; rep = 1'b0;
            run_t = 0; last_val = '0; done_st = 1'b0; mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                etg_pkg::CFG_EASE_TYPE: ease_code = data[4:0];
                etg_pkg::CFG_START:     start_val = data;
                etg_pkg::CFG_END:       end_val = data;
                etg_pkg::CFG_DURATION:  dur = data[23:0];
                etg_pkg::CFG_DELAY:     dly = data[23:0];
                etg_pkg::CFG_REPEAT:    rep = data[0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b) >>> 16;
        endfunction

        function longint qpow(longint x, int n);
            longint r;
            r = x;
            for (int i = 1; i < n; i++) r = qmul(r, x);
            return r;
        endfunction

        function longint qsqrt(longint v);
            if (v < 0) v = 0;
            return longint'(int_sqrt(longint'(v) << 16));
        endfunction

        // 2^(-x) for a non-negative phase-format x, via a chain of square-root factors.
        function longint exp2_neg(longint x);
            longint unsigned n, f, r, c;
            n = longint'(x) >> 16;
            f = x & (P_ONE - 1);
            r = 64'd1 << 30;
            c = int_sqrt(64'd1 << 59);
            for (int k = 1; k <= 16; k++) begin
                if ((f >> (16 - k)) & 1) r = (r * c) >> 30;
                c = int_sqrt(c << 30);
            end
            if (n >= 31) return 0;
            r = r >> n;
            return longint'(r >> 14);
        endfunction

        // Rotates by p * pi/2 and returns sine and cosine in Q2.30, clamped to [0, 1].
        function void rotate(longint p, output longint s, output longint c);
            longint z, x, y, nx;
            z = (p * longint'(etg_pkg::HALF_PI_Q30)) >>> 16;
            x = longint'(etg_pkg::CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < etg_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); y = y + (x >>> i);
                    z = z - longint'(etg_pkg::ATAN_Q30[i]);
                end else begin
                    nx = x + (y >>> i); y = y - (x >>> i);
                    z = z + longint'(etg_pkg::ATAN_Q30[i]);
                end
                x = nx;
            end
            if (x < 0) x = 0;
            if (x > (64'd1 << 30)) x = 64'd1 << 30;
            if (y < 0) y = 0;
            if (y > (64'd1 << 30)) y = 64'd1 << 30;
            s = y;
            c = x;
        endfunction

        function longint bounce_curve(longint p);
            longint u, k, p11;
            p11 = 11 * p;
            if (p11 < 4 * P_ONE) begin u = p11; k = 0; end
            else if (p11 < 8 * P_ONE) begin u = p11 - 6 * P_ONE; k = 49152; end
            else if (p11 < 10 * P_ONE) begin u = p11 - 9 * P_ONE; k = 61440; end
            else begin u = p11 - 688128; k = 64512; end
            if (u < 0) u = -u;
            return ((u * u) >>> 20) + k;
        endfunction

        function longint eased_phase(longint p);
            longint s, c, a, q;
            int n, kind;
            q = P_ONE - p;
            if (ease_code >= etg_pkg::EASE_POLY_FIRST && ease_code <= etg_pkg::EASE_POLY_LAST)
            begin
                n = (int'(ease_code) - 1) / 3 + 2;
                kind = (int'(ease_code) - 1) % 3;
                if (kind == 0) return qpow(p, n);
                if (kind == 1) return P_ONE - qpow(q, n);
                if (p < P_HALF) return qpow(2 * p, n) >>> 1;
                return P_ONE - (qpow(2 * q, n) >>> 1);
            end
            // All bounce codes share the out-bounce curve.
            if (ease_code >= etg_pkg::EASE_BOUNCE_FIRST
                && ease_code <= etg_pkg::EASE_BOUNCE_LAST)
                return bounce_curve(p);
            case (ease_code)
                etg_pkg::EASE_SINE_IN: begin rotate(p, s, c); return P_ONE - (c >>> 14); end
                etg_pkg::EASE_SINE_OUT: begin rotate(p, s, c); return s >>> 14; end
                etg_pkg::EASE_SINE_INOUT: begin
                    rotate(p, s, c);
                    return longint'((longint'(unsigned'(s)) * s) >> 44);
                end
                etg_pkg::EASE_EXPO_IN: return exp2_neg(10 * P_ONE - 10 * p);
                etg_pkg::EASE_EXPO_OUT: return P_ONE - exp2_neg(10 * p);
                etg_pkg::EASE_EXPO_INOUT: begin
                    if (p < P_HALF) return exp2_neg(11 * P_ONE - 20 * p);
                    return P_ONE - exp2_neg(20 * p - 9 * P_ONE);
                end
                etg_pkg::EASE_CIRC_IN: return P_ONE - qsqrt(P_ONE - qmul(p, p));
                etg_pkg::EASE_CIRC_OUT: return qsqrt(P_ONE - qmul(q, q));
                etg_pkg::EASE_CIRC_INOUT: begin
                    if (p < P_HALF) begin
                        a = 2 * p;
                        return (P_ONE - qsqrt(P_ONE - qmul(a, a))) >>> 1;
                    end
                    a = 2 * q;
                    return (qsqrt(P_ONE - qmul(a, a)) + P_ONE) >>> 1;
                end
                default: return p;
            endcase
        endfunction

        // Advances the predicted state by one accepted tick.
        function void note_tick(logic [15:0] el, logic hold);
            t_tween_out r;
            longint unsigned t, endp;
            longint st, en, p, e, v;
            st = longint'(signed'(start_val));
            en = longint'(signed'(end_val));
            r.wrapped = 1'b0;
            if (hold) begin
                r.value = last_val;
                r.done_res = done_st;
                expected_q.push_back(r);
                return;
            end
            t = run_t + el;
            if (t > T_MAX) t = T_MAX;
            endp = longint'(dly) + longint'(dur);
            if (endp > T_MAX) endp = T_MAX;
            if (t >= endp) begin
                if (rep) begin
                    t = 0; done_st = 1'b0; v = st; r.wrapped = 1'b1;
                end else begin
                    v = en; done_st = 1'b1;
                end
            end else if (t <= dly || dur == 0) begin
                v = st;
            end else begin
                p = longint'(((t - dly) << 16) / dur);
                if (p > P_ONE) p = P_ONE;
                e = eased_phase(p);
                if (e < 0) e = 0;
                if (e > P_ONE) e = P_ONE;
                v = st + (((en - st) * e) >>> 16);
            end
            run_t = t;
            last_val = v[31:0];
            r.value = last_val;
            r.done_res = done_st;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] user);
            t_tween_out x;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h user=%b", value, user);
                return;
            end
            x = expected_q.pop_front();
            if (x.value !== value || x.done_res !== user[0] || x.wrapped !== user[1]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h done=%b wrap=%b, got %h %b %b",
                             x.value, x.done_res, x.wrapped, value, user[0], user[1]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    tween_scoreboard sb = new();
    int  quiet_cycles = 0;
    int  hold_off_cycles = 0;
    bit  steady = 1'b0;

    easing_tween_generator dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Monitor all three channels and keep the watchdog count.
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        if (i_s_axis_tvalid && o_s_axis_tready) sb.note_tick(i_s_axis_tdata, i_s_axis_tuser[0]);
        if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_easing_tween_generator: FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, with one long hold-off in the third random segment.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // One register write; valid is low for a cycle before the next write starts.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_tick(logic [15:0] el, logic hold);
        int gap;
        if (!steady && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 6);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= el;
        i_s_axis_tuser <= hold;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Sender pause: lower valid and wait until every result has come back.
    // The first edge lets the monitor record the last accepted tick.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_all(logic [4:0] ease, logic [31:0] sv, logic [31:0] ev,
                           logic [23:0] dur, logic [23:0] dly, logic rep);
        write_reg(etg_pkg::CFG_EASE_TYPE, {27'd0, ease});
        write_reg(etg_pkg::CFG_START, sv);
        write_reg(etg_pkg::CFG_END, ev);
        write_reg(etg_pkg::CFG_DURATION, {8'd0, dur});
        write_reg(etg_pkg::CFG_DELAY, {8'd0, dly});
        write_reg(etg_pkg::CFG_REPEAT, {31'd0, rep});
    endtask

    // Brings the time counter back to zero through a zero-length repeating run.
    task automatic rewind();
        write_reg(etg_pkg::CFG_REPEAT, 32'd1);
        write_reg(etg_pkg::CFG_DURATION, 32'd0);
        write_reg(etg_pkg::CFG_DELAY, 32'd0);
        send_tick(16'd1, 1'b0);
        drain();
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int items;
        int seg;
        int n;
        logic [23:0] dur, dly;
        logic [15:0] el;
        items = 0;
        seg = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: hold right after reset, delay boundary, full-range linear run, end.
        send_tick(16'hFFFF, 1'b1);
        drain();
        set_all(5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 24'd16, 24'd4, 1'b0);
        send_tick(16'd0, 1'b0);
        send_tick(16'd4, 1'b0);
        send_tick(16'd1, 1'b0);
        send_tick(16'd7, 1'b0);
        send_tick(16'd0, 1'b1);
        send_tick(16'd8, 1'b0);
        send_tick(16'd3, 1'b0);
        drain();
        // Done stays set across a register change.
        write_reg(etg_pkg::CFG_END, 32'h0001_0000);
        send_tick(16'd2, 1'b0);
        send_tick(16'd0, 1'b1);
        drain();
        // Zero duration with repeat and no delay wraps on every tick that is not held.
        set_all(5'd31, 32'h1234_5678, 32'hFFFF_0000, 24'd0, 24'd0, 1'b1);
        send_tick(16'd0, 1'b0);
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'd5, 1'b1);
        drain();
        // Saturating counter: largest run and delay, largest steps.
        set_all(etg_pkg::EASE_BOUNCE_FIRST, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF,
                24'hFFFFFF, 1'b0);
        send_tick(16'hFFFF, 1'b0);
        repeat (4) send_tick(16'hFFFF, 1'b0);
        drain();
        rewind();
        set_all(etg_pkg::EASE_SINE_INOUT, 32'h0, 32'h0010_0000, 24'd3, 24'd0, 1'b0);
        send_tick(16'd1, 1'b0);
        send_tick(16'd1, 1'b0);
        send_tick(16'd1, 1'b0);
        drain();

        // Random segments, each with a fresh setting.
        while (items < 1900) begin
            seg++;
            if ($urandom_range(0, 3) != 0) rewind();
            case ($urandom_range(0, 9))
                0: dur = 24'd0;
                1: dur = $urandom_range(0, 24'hFFFFFF);
                2: dur = 24'hFFFFFF;
                default: dur = $urandom_range(1, 300);
            endcase
            case ($urandom_range(0, 9))
                0: dly = $urandom_range(0, 24'hFFFFFF);
                1: dly = 24'hFFFFFF;
                default: dly = $urandom_range(0, 30);
            endcase
            set_all($urandom_range(0, 31), pick_value(), pick_value(), dur, dly,
                    $urandom_range(0, 1));
            steady = (seg % 12 == 5);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: el = $urandom;
                    3, 4, 5: el = $urandom_range(0, 3);
                    default: el = $urandom_range(0, (dur > 24'd600) ? 100 : dur / 6 + 1);
                endcase
                if (seg == 3 && i == 5) hold_off_cycles = 400;
                send_tick(el, $urandom_range(0, 9) == 0);
                items++;
            end
            drain();
            steady = 1'b0;
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("tb_easing_tween_generator: PASS");
        end else begin
            $display("tb_easing_tween_generator: FAIL");
        end
        $finish;
    end
endmodule
